// File: src/abofc_pkg.sv
// Shared types, codes and the divide-by-255 helper for the ARGB over-blend compositor.
`default_nettype none

package abofc_pkg;

  typedef logic [1:0] action_t;
  typedef logic [7:0] chan_t;

  localparam action_t ACT_FILL    = 2'd0;
  localparam action_t ACT_COMPOSE = 2'd1;
  localparam action_t ACT_READ    = 2'd2;
  localparam action_t ACT_NONE    = 2'd3;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [31:0] BG_PIXEL   = 32'h000A_0A0F;
  localparam chan_t       FULL_ALPHA = 8'hFF;

  // floor(n / 255) for n <= 255*255
  function automatic chan_t div255(input logic [15:0] n);
    logic [16:0] t;
    t = {1'b0, n} + 17'd1 + {9'd0, n[15:8]};
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

// File: src/argb_over_blend_frame_compositor.sv
// Top level: ARGB source-over frame compositor with a read-modify-write frame store.
//
// Input channel (in_valid/in_ready) takes one word per cycle while in_ready is
// high: fill a pixel with the background color, compose a source pixel onto the
// stored pixel, or read a pixel. Result channel (out_valid/out_ready) returns one
// word per input word, in order: the stored pixel after the operation (zero for
// ACT_NONE or outside the frame) and a status bit (1 = outside the frame).
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set frame width and height
// and take effect at the next clock edge; write them only while the block is
// idle. Throughput: one word per cycle while the receiver keeps up, set by the
// single-port-read / single-port-write frame store; same-pixel hazards are covered
// by forwarding, so no bubbles. When the receiver stalls, words collect in the
// two pipeline stages and the output register; in_ready drops only when all three
// are full. Reset clears the pipeline and sets both frame registers to 128; frame
// store contents are undefined until filled.
`default_nettype none

module argb_over_blend_frame_compositor
  import abofc_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [6:0]  in_pos_x,
  input  wire logic [6:0]  in_pos_y,
  input  wire logic [31:0] in_src_pixel,
  input  wire logic        in_src_has_alpha,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_pixel,
  output logic             out_status,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [7:0] frame_width_r;
  logic [7:0] frame_height_r;

  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] rd_data_r;

  logic              p1_valid_r;
  action_t           p1_action_r;
  logic              p1_outside_r;
  logic [ADDR_W-1:0] p1_addr_r;
  logic [31:0]       p1_src_r;
  logic              p1_has_alpha_r;

  logic              p2_valid_r;
  action_t           p2_action_r;
  logic              p2_outside_r;
  logic [ADDR_W-1:0] p2_addr_r;
  logic [31:0]       p2_src_r;
  logic              p2_has_alpha_r;
  logic [31:0]       p2_dst_r;
  logic [15:0]       p2_prod_s_r [3];
  logic [15:0]       p2_prod_d_r [3];

  logic              wr_valid_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [31:0]       wr_data_r;

  logic        out_valid_r;
  logic [31:0] out_read_pixel_r;
  logic        out_status_r;

  logic              out_en, p2_adv, p2_free, p1_adv, p1_free, in_fire;
  logic [ADDR_W-1:0] in_addr;
  logic              in_outside;
  logic [31:0]       p1_dst;
  chan_t             p1_alpha;
  logic [15:0]       prod_s_nxt [3];
  logic [15:0]       prod_d_nxt [3];
  logic              p2_wr, mem_we;
  logic [31:0]       p2_pixel;
  logic              p2_status;
  logic [31:0]       blend_px, compose_px;
  chan_t             p2_alpha;

  // handshake and stage advance
  assign out_en   = !out_valid_r || out_ready;
  assign p2_adv   = p2_valid_r && out_en;
  assign p2_free  = !p2_valid_r || out_en;
  assign p1_adv   = p1_valid_r && p2_free;
  assign p1_free  = !p1_valid_r || p2_free;
  assign in_ready = p1_free;
  assign in_fire  = in_valid && p1_free;

  assign in_addr = ADDR_W'(int'(in_pos_y) * MAX_WIDTH + int'(in_pos_x));
  assign in_outside = ({1'b0, in_pos_x} >= frame_width_r) ||
                      ({1'b0, in_pos_y} >= frame_height_r) ||
                      (int'(in_pos_x) >= MAX_WIDTH) ||
                      (int'(in_pos_y) >= MAX_HEIGHT);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 8'd128;
      frame_height_r <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
      endcase
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[p2_addr_r] <= p2_pixel;
    end
    if (in_fire) begin
      rd_data_r <= mem[in_addr];
    end
  end

  // stage 1: forward newest write, then multiply
  assign p1_dst = (p2_wr && (p2_addr_r == p1_addr_r)) ? p2_pixel :
                  (wr_valid_r && (wr_addr_r == p1_addr_r)) ? wr_data_r : rd_data_r;
  assign p1_alpha = p1_src_r[31:24];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_s_nxt[i] = {8'd0, p1_src_r[8*i +: 8]} * {8'd0, p1_alpha};
      prod_d_nxt[i] = {8'd0, p1_dst[8*i +: 8]} * {8'd0, FULL_ALPHA - p1_alpha};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_fire) begin
      p1_valid_r <= 1'b1;
    end else if (p1_adv) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_action_r    <= in_action;
      p1_outside_r   <= in_outside;
      p1_addr_r      <= in_addr;
      p1_src_r       <= in_src_pixel;
      p1_has_alpha_r <= in_src_has_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (p1_adv) begin
      p2_valid_r <= 1'b1;
    end else if (p2_adv) begin
      p2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      p2_action_r    <= p1_action_r;
      p2_outside_r   <= p1_outside_r;
      p2_addr_r      <= p1_addr_r;
      p2_src_r       <= p1_src_r;
      p2_has_alpha_r <= p1_has_alpha_r;
      p2_dst_r       <= p1_dst;
      p2_prod_s_r    <= prod_s_nxt;
      p2_prod_d_r    <= prod_d_nxt;
    end
  end

  // stage 2: divide, select, write back
  assign p2_alpha = p2_src_r[31:24];
  assign blend_px = {8'd0,
                     div255(p2_prod_s_r[2] + p2_prod_d_r[2]),
                     div255(p2_prod_s_r[1] + p2_prod_d_r[1]),
                     div255(p2_prod_s_r[0] + p2_prod_d_r[0])};

  always_comb begin
    if (!p2_has_alpha_r || (p2_alpha == FULL_ALPHA)) begin
      compose_px = p2_src_r;
    end else if (p2_alpha == 8'd0) begin
      compose_px = p2_dst_r;
    end else begin
      compose_px = blend_px;
    end
  end

  always_comb begin
    p2_status = 1'b0;
    unique case (p2_action_r)
      ACT_FILL:    p2_pixel = BG_PIXEL;
      ACT_COMPOSE: p2_pixel = compose_px;
      ACT_READ:    p2_pixel = p2_dst_r;
      ACT_NONE:    p2_pixel = '0;
    endcase
    if (p2_outside_r && (p2_action_r != ACT_NONE)) begin
      p2_pixel  = '0;
      p2_status = 1'b1;
    end
  end

  assign p2_wr  = p2_valid_r && !p2_outside_r &&
                  ((p2_action_r == ACT_FILL) || (p2_action_r == ACT_COMPOSE));
  assign mem_we = p2_wr && p2_adv;

  // most recent write, covers a read issued in the same cycle as that write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_valid_r <= 1'b0;
    end else if (mem_we) begin
      wr_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wr_addr_r <= p2_addr_r;
      wr_data_r <= p2_pixel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p2_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_adv) begin
      out_read_pixel_r <= p2_pixel;
      out_status_r     <= p2_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_pixel = out_read_pixel_r;
  assign out_status     = out_status_r;

  a_status_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_read_pixel_r == '0)
    else $error("out-of-frame word carries a nonzero pixel");

  a_no_write_under_stall: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && !p1_adv |-> !mem_we)
    else $error("frame store written while stage 1 holds");

  a_full_pipe_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && p2_valid_r && !out_en |-> !in_ready)
    else $error("input accepted with a full pipeline");

endmodule

`default_nettype wire
